[design/sort_and_search_engine_core_assert.svh]
// Assertion macros used by the checker file.
`ifndef SORT_AND_SEARCH_ENGINE_CORE_ASSERT_SVH
`define SORT_AND_SEARCH_ENGINE_CORE_ASSERT_SVH
`define SSE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[design/sse_pkg.sv]
`timescale 1ns / 1ps
package sse_pkg;
  localparam int Depth = 1024;
  localparam int AddrW = $clog2(Depth);
  localparam int CntW = AddrW + 1;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_SEARCH = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] value;
    logic signed [31:0] key;
  } in_beat_t;

  typedef struct packed {
    logic       linear_found;
    logic [9:0] linear_index;
    logic [10:0] linear_probes;
    logic       sorted_found;
    logic [9:0] sorted_index;
    logic [3:0] sorted_probes;
    logic       overflow_flag;
  } out_beat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LIN_RD,
    ST_LIN_CMP,
    ST_CPY_RD,
    ST_CPY_WR,
    ST_SRT_RD,
    ST_SRT_CMP,
    ST_SWP_RDI,
    ST_SWP_WR,
    ST_BIN_RD,
    ST_BIN_CMP,
    ST_OUT
  } state_t;
endpackage

[design/sse_ram.sv]
`timescale 1ns / 1ps
module sse_ram
  import sse_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [AddrW-1:0]  waddr,
  input  logic [31:0]       wdata,
  input  logic [AddrW-1:0]  raddr,
  output logic [31:0]       rdata
);
  logic [31:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[design/sort_and_search_engine_core.sv]
`timescale 1ns / 1ps
// A load, clear or unused-code beat is taken in the idle state. A search runs the linear
// probes (read, compare), then the binary probes (read, compare), and then presents the
// result beat, which it holds while out_stall is high.
// The first search after a load also copies and selection sorts the store, after its
// linear probes and before its binary probes. One beat is in work at a time.
// Reset (rst_n low, synchronous) empties the store and clears the overflow flag.
module sort_and_search_engine_core
  import sse_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);
  state_t state_r, state_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic sorted_valid_r, sorted_valid_nxt, drop_r, drop_nxt;
  logic signed [31:0] key_r, key_nxt, least_r, least_nxt, vi_r, vi_nxt;
  logic [CntW-1:0] i_r, i_nxt, j_r, j_nxt, pos_r, pos_nxt;
  logic [CntW:0] lo_r, lo_nxt, hi_r, hi_nxt;
  out_beat_t res_r, res_nxt;
  logic out_valid_r, out_valid_nxt;

  logic lwe, swe;
  logic [AddrW-1:0] lwaddr, lraddr, swaddr, sraddr;
  logic [31:0] lwdata, swdata, lrdata, srdata;
  logic signed [31:0] lrd_s, srd_s;
  logic [CntW:0] mid;
  logic accept;

  sse_ram u_lstore (.clk, .we(lwe), .waddr(lwaddr), .wdata(lwdata),
                    .raddr(lraddr), .rdata(lrdata));
  sse_ram u_sstore (.clk, .we(swe), .waddr(swaddr), .wdata(swdata),
                    .raddr(sraddr), .rdata(srdata));

  assign lrd_s = lrdata;
  assign srd_s = srdata;
  assign in_stall = (state_r != ST_IDLE);
  assign accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data = res_r;
  assign mid = ((hi_r - lo_r + 1'b1) >> 1) + lo_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_data.operation == OP_SEARCH) begin
          state_nxt = (count_r == '0) ? ST_OUT : ST_LIN_RD;
        end
      end
      ST_LIN_RD: state_nxt = ST_LIN_CMP;
      ST_LIN_CMP: begin
        if (lrd_s == key_r || i_r + 1'b1 == count_r) begin
          state_nxt = sorted_valid_r ? ST_BIN_RD : ST_CPY_RD;
        end else begin
          state_nxt = ST_LIN_RD;
        end
      end
      ST_CPY_RD: state_nxt = ST_CPY_WR;
      ST_CPY_WR: state_nxt = (i_r + 1'b1 == count_r) ? ST_SRT_RD : ST_CPY_RD;
      ST_SRT_RD: state_nxt = ST_SRT_CMP;
      ST_SRT_CMP: state_nxt = (j_r + 1'b1 >= count_r) ? ST_SWP_RDI : ST_SRT_RD;
      ST_SWP_RDI: state_nxt = ST_SWP_WR;
      ST_SWP_WR: state_nxt = (i_r + 2'd2 >= count_r) ? ST_BIN_RD : ST_SRT_RD;
      ST_BIN_RD: state_nxt = (hi_r[CntW] || hi_r < lo_r) ? ST_OUT : ST_BIN_CMP;
      ST_BIN_CMP: state_nxt = (srd_s == key_r) ? ST_OUT : ST_BIN_RD;
      ST_OUT: state_nxt = (out_valid_r && !out_stall) ? ST_IDLE : ST_OUT;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    sorted_valid_nxt = sorted_valid_r;
    drop_nxt = drop_r;
    key_nxt = key_r;
    least_nxt = least_r;
    vi_nxt = vi_r;
    i_nxt = i_r;
    j_nxt = j_r;
    pos_nxt = pos_r;
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    res_nxt = res_r;
    out_valid_nxt = out_valid_r;
    lwe = 1'b0;
    lwaddr = count_r[AddrW-1:0];
    lwdata = in_data.value;
    lraddr = i_r[AddrW-1:0];
    swe = 1'b0;
    swaddr = i_r[AddrW-1:0];
    swdata = lrdata;
    sraddr = j_r[AddrW-1:0];
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_data.operation)
            OP_LOAD: begin
              if (count_r < CntW'(Depth)) begin
                lwe = 1'b1;
                count_nxt = count_r + 1'b1;
                sorted_valid_nxt = 1'b0;
              end else begin
                drop_nxt = 1'b1;
              end
            end
            OP_CLEAR: begin
              count_nxt = '0;
              sorted_valid_nxt = 1'b0;
              drop_nxt = 1'b0;
            end
            OP_SEARCH: begin
              key_nxt = in_data.key;
              i_nxt = '0;
              res_nxt = '0;
              res_nxt.overflow_flag = drop_r;
              lo_nxt = '0;
              hi_nxt = {1'b0, count_r} - 1'b1;
              out_valid_nxt = (count_r == '0);
            end
            default: ;
          endcase
        end
      end
      ST_LIN_CMP: begin
        res_nxt.linear_probes = 11'(i_r + 1'b1);
        if (lrd_s == key_r) begin
          res_nxt.linear_found = 1'b1;
          res_nxt.linear_index = i_r[9:0];
        end
        if (lrd_s == key_r || i_r + 1'b1 == count_r) begin
          i_nxt = '0;
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      ST_CPY_WR: begin
        swe = 1'b1;
        if (i_r + 1'b1 == count_r) begin
          i_nxt = '0;
          j_nxt = '0;
          pos_nxt = '0;
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      ST_SRT_CMP: begin
        if (j_r == i_r) begin
          vi_nxt = srd_s;
        end
        if (j_r == i_r || srd_s < least_r) begin
          least_nxt = srd_s;
          pos_nxt = j_r;
        end
        if (j_r + 1'b1 >= count_r) begin
          j_nxt = i_r;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      ST_SWP_RDI: begin
        swe = 1'b1;
        swaddr = i_r[AddrW-1:0];
        swdata = least_r;
      end
      ST_SWP_WR: begin
        swe = 1'b1;
        swaddr = pos_r[AddrW-1:0];
        swdata = vi_r;
        i_nxt = i_r + 1'b1;
        j_nxt = i_r + 1'b1;
        if (i_r + 2'd2 >= count_r) begin
          sorted_valid_nxt = 1'b1;
        end
      end
      ST_BIN_RD: begin
        sraddr = mid[AddrW-1:0];
        if (hi_r[CntW] || hi_r < lo_r) begin
          out_valid_nxt = 1'b1;
        end
      end
      ST_BIN_CMP: begin
        res_nxt.sorted_probes = res_r.sorted_probes + 1'b1;
        if (srd_s == key_r) begin
          res_nxt.sorted_found = 1'b1;
          res_nxt.sorted_index = mid[9:0];
          out_valid_nxt = 1'b1;
        end else if (srd_s < key_r) begin
          lo_nxt = mid + 1'b1;
        end else begin
          hi_nxt = mid - 1'b1;
        end
      end
      ST_OUT: begin
        if (out_valid_r && !out_stall) begin
          out_valid_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      sorted_valid_r <= 1'b0;
      drop_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      sorted_valid_r <= sorted_valid_nxt;
      drop_r <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
    key_r <= key_nxt;
    least_r <= least_nxt;
    vi_r <= vi_nxt;
    i_r <= i_nxt;
    j_r <= j_nxt;
    pos_r <= pos_nxt;
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    res_r <= res_nxt;
  end
endmodule

[design/sse_checker.sv]
`timescale 1ns / 1ps
`include "sort_and_search_engine_core_assert.svh"
module sse_checker
  import sse_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_beat_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_beat_t out_data
);
  `SSE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
  `SSE_ASSERT_IMPL(a_busy_out, clk, rst_n, out_valid, in_stall)
  `SSE_ASSERT_IMPL(a_lin_idx, clk, rst_n, out_valid && !out_data.linear_found, out_data.linear_index == 10'd0)
  `SSE_ASSERT_IMPL(a_bin_idx, clk, rst_n, out_valid && !out_data.sorted_found, out_data.sorted_index == 10'd0)
endmodule

bind sort_and_search_engine_core sse_checker u_sse_checker (.*);

[tb/tb_sort_and_search_engine_core.sv]
`timescale 1ns / 1ps
module tb_sort_and_search_engine_core;
  import sse_pkg::*;

  localparam int StallLimit = 4000000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_beat_t out_data;

  sort_and_search_engine_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic signed [31:0] load_vals [Depth];
  logic signed [31:0] sorted_vals [Depth];
  int unsigned        num_loaded;
  bit                 sort_fresh;
  bit                 load_dropped;
  out_beat_t          search_results_q [$];

  int errors;
  int searches_sent;
  int loads_sent;
  int results_seen;
  int idle_cycles;
  bit quiet_mode;
  int out_hold;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (quiet_mode || r < 60) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(50, 15);
  endfunction

  function automatic void sort_copy();
    int i, j, pos;
    logic signed [31:0] least;
    for (i = 0; i < num_loaded; i++) sorted_vals[i] = load_vals[i];
    for (i = 0; i < num_loaded; i++) begin
      least = sorted_vals[i];
      pos = i;
      for (j = i + 1; j < num_loaded; j++) begin
        if (sorted_vals[j] < least) begin
          least = sorted_vals[j];
          pos = j;
        end
      end
      sorted_vals[pos] = sorted_vals[i];
      sorted_vals[i] = least;
    end
    sort_fresh = 1'b1;
  endfunction

  function automatic void predict_search_result(in_beat_t b);
    out_beat_t r;
    int i, lo, hi, mid, lprobes, bprobes;
    r = '0;
    lprobes = 0;
    for (i = 0; i < num_loaded; i++) begin
      lprobes++;
      if (load_vals[i] == b.key) begin
        r.linear_found = 1'b1;
        r.linear_index = i[9:0];
        break;
      end
    end
    r.linear_probes = lprobes[10:0];
    bprobes = 0;
    if (num_loaded > 0) begin
      if (!sort_fresh) sort_copy();
      lo = 0;
      hi = num_loaded - 1;
      while (hi >= lo) begin
        mid = (hi - lo + 1) / 2 + lo;
        bprobes++;
        if (sorted_vals[mid] == b.key) begin
          r.sorted_found = 1'b1;
          r.sorted_index = mid[9:0];
          break;
        end else if (sorted_vals[mid] < b.key) begin
          lo = mid + 1;
        end else begin
          hi = mid - 1;
        end
      end
    end
    r.sorted_probes = bprobes[3:0];
    r.overflow_flag = load_dropped;
    search_results_q.push_back(r);
  endfunction

  function automatic void model_accept(in_beat_t b);
    case (op_t'(b.operation))
      OP_LOAD: begin
        loads_sent++;
        if (num_loaded < Depth) begin
          load_vals[num_loaded] = b.value;
          num_loaded++;
          sort_fresh = 1'b0;
        end else begin
          load_dropped = 1'b1;
        end
      end
      OP_CLEAR: begin
        num_loaded = 0;
        sort_fresh = 1'b0;
        load_dropped = 1'b0;
      end
      OP_SEARCH: begin
        searches_sent++;
        predict_search_result(b);
      end
      default: ;
    endcase
  endfunction

  task automatic send_beat(op_t op, logic signed [31:0] value, logic signed [31:0] key);
    in_beat_t b;
    int gap;
    b.operation = op;
    b.value = value;
    b.key = key;
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    model_accept(b);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic load_value(logic signed [31:0] v);
    send_beat(OP_LOAD, v, $urandom());
  endtask

  task automatic search_key(logic signed [31:0] k);
    send_beat(OP_SEARCH, $urandom(), k);
  endtask

  task automatic clear_store();
    send_beat(OP_CLEAR, $urandom(), $urandom());
  endtask

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    out_beat_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_hold <= 0;
      idle_cycles <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (search_results_q.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = search_results_q.pop_front();
          if (out_data.linear_found !== want.linear_found)
            report_mismatch("linear_found", out_data.linear_found, want.linear_found);
          if (out_data.linear_index !== want.linear_index)
            report_mismatch("linear_index", out_data.linear_index, want.linear_index);
          if (out_data.linear_probes !== want.linear_probes)
            report_mismatch("linear_probes", out_data.linear_probes, want.linear_probes);
          if (out_data.sorted_found !== want.sorted_found)
            report_mismatch("sorted_found", out_data.sorted_found, want.sorted_found);
          if (out_data.sorted_index !== want.sorted_index)
            report_mismatch("sorted_index", out_data.sorted_index, want.sorted_index);
          if (out_data.sorted_probes !== want.sorted_probes)
            report_mismatch("sorted_probes", out_data.sorted_probes, want.sorted_probes);
          if (out_data.overflow_flag !== want.overflow_flag)
            report_mismatch("overflow_flag", out_data.overflow_flag, want.overflow_flag);
        end
      end
      if (out_hold > 0) begin
        out_hold <= out_hold - 1;
        out_stall <= 1'b1;
      end else if (!quiet_mode && $urandom_range(99) < 25) begin
        out_hold <= ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(2);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
        $display("FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (search_results_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    search_key(32'sd5);
    send_beat(OP_NONE, 32'sd1, 32'sd1);
    load_value(32'h7FFF_FFFF);
    load_value(32'h8000_0000);
    load_value(32'sd0);
    load_value(-32'sd1);
    load_value(32'sd0);
    load_value(32'sd42);
    search_key(32'h8000_0000);
    search_key(32'h7FFF_FFFF);
    search_key(32'sd0);
    search_key(32'sd7);
    search_key(-32'sd2);
    load_value(32'sd7);
    search_key(32'sd7);
    send_beat(OP_NONE, 32'sd7, 32'sd7);
    clear_store();
    search_key(32'sd0);
    load_value(32'sd3);
    search_key(32'sd3);
    search_key(32'sd4);
    search_key(32'sd2);
  endtask

  task automatic test_random(int n_items);
    int sent, n, k, i;
    logic signed [31:0] pool [8];
    sent = 0;
    while (sent < n_items) begin
      quiet_mode = ($urandom_range(9) == 0);
      for (i = 0; i < 8; i++) begin
        case ($urandom_range(3))
          0: pool[i] = $urandom_range(20);
          1: pool[i] = $urandom_range(3) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
          default: pool[i] = $urandom();
        endcase
      end
      if ($urandom_range(3) != 0) begin
        clear_store();
        sent++;
      end
      n = ($urandom_range(19) == 0) ? $urandom_range(60, 30) : $urandom_range(12);
      for (i = 0; i < n; i++) begin
        load_value($urandom_range(3) == 0 ? $urandom() : pool[$urandom_range(7)]);
        sent++;
      end
      k = $urandom_range(6, 1);
      for (i = 0; i < k; i++) begin
        case ($urandom_range(9))
          0: send_beat(OP_NONE, $urandom(), $urandom());
          1: load_value(pool[$urandom_range(7)]);
          2, 3: search_key($urandom());
          default: search_key(pool[$urandom_range(7)]);
        endcase
        sent++;
      end
    end
    quiet_mode = 1'b0;
  endtask

  task automatic test_drain_pause();
    load_value(32'sd9);
    search_key(32'sd9);
    search_key(32'sd10);
    wait_results_drained();
    search_key(32'sd9);
  endtask

  task automatic test_full_store();
    int i;
    clear_store();
    for (i = 0; i < Depth; i++) load_value($urandom_range(5000));
    search_key(load_vals[Depth - 1]);
    load_value(32'sd1);
    load_value(32'sd2);
    search_key(-32'sd1);
    search_key(load_vals[0]);
    clear_store();
    load_value(32'sd1);
    search_key(32'sd1);
  endtask

  initial begin
    errors = 0;
    searches_sent = 0;
    loads_sent = 0;
    results_seen = 0;
    quiet_mode = 1'b0;
    num_loaded = 0;
    sort_fresh = 1'b0;
    load_dropped = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_drain_pause();
    test_random(540);
    test_full_store();
    wait_results_drained();
    repeat (50) @(posedge clk);
    $display("Sent %0d loads and %0d searches, %0d results checked.",
             loads_sent, searches_sent, results_seen);
    $display("Covered empty, duplicate, extreme, unused-code and full-store overflow cases.");
    if (errors == 0 && search_results_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
